// ===== hw/rtl/tfun_pkg.sv =====
// ----------------------------------------------------------------------------
// tfun_pkg
// Shared widths for the triangle facet unit normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tfun_pkg;

  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 14;
  localparam int NORM_W    = FRAC_BITS + 2;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int MAG_W     = 2 * COORD_W + 1;
  localparam int LO_W      = (MAG_W + 1) / 2;
  localparam int HI_W      = MAG_W - LO_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int LEN2_W    = SQ_W + 2;
  localparam int ROOT_STEPS = FRAC_BITS + 1;
  localparam int Q_W       = ROOT_STEPS;
  localparam int REM_W     = SQ_W + 2 * FRAC_BITS;
  localparam int P_W       = LEN2_W + Q_W;
  localparam int T_W       = P_W + ROOT_STEPS + 1;
  localparam int IN_W      = 9 * COORD_W;
  localparam int OUT_W     = 3 * NORM_W;

endpackage

`default_nettype wire

// ===== hw/rtl/triangle_facet_unit_normal_top.sv =====
// Unit normal of one triangle per clock unless back pressure stalls it. Each
// cycle a request with three Q12.12 vertices may enter; the result (Q1.14
// normal and a degenerate flag) leaves the output register. The depth is set
// by the exact square-root quotient, resolved one bit per stage over 15 stages
// after 6 stages of differences, cross product and squaring. Back pressure
// stalls the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
// triangle_facet_unit_normal_top
// Cross product of two triangle edges divided by its length, exact truncation.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_facet_unit_normal_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
  input  wire logic [tfun_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [tfun_pkg::OUT_W-1:0]       m_axis_tdata,
  // degenerate
  output logic                             m_axis_tuser
);

  localparam int CW  = tfun_pkg::COORD_W;
  localparam int NS  = tfun_pkg::ROOT_STEPS;
  localparam int NW  = tfun_pkg::NORM_W;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [CW-1:0] vin [0:8];
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      vin[i] = signed'(s_axis_tdata[i*CW +: CW]);
    end
  end

  // stage 1: edges a = v0 - v1, b = v1 - v2 (index 0..2 a, 3..5 b)
  logic                                  v1;
  logic signed [tfun_pkg::DIFF_W-1:0]    dif [0:5];
  // stage 2: products
  logic                                  v2;
  logic signed [tfun_pkg::PROD_W-1:0]    prd [0:5];
  // stage 3: cross magnitude and sign
  logic                                  v3;
  logic [tfun_pkg::MAG_W-1:0]            mag [0:2];
  logic [2:0]                            neg3;
  logic                                  dg3;
  // stage 4: square partial products
  logic                                  v4;
  logic [2*tfun_pkg::HI_W-1:0]           pp_hh [0:2];
  logic [tfun_pkg::HI_W+tfun_pkg::LO_W-1:0] pp_hl [0:2];
  logic [2*tfun_pkg::LO_W-1:0]           pp_ll [0:2];
  logic [2:0]                            neg4;
  logic                                  dg4;
  // stage 5: squares
  logic                                  v5;
  logic [tfun_pkg::SQ_W-1:0]             sq [0:2];
  logic [2:0]                            neg5;
  logic                                  dg5;
  // root stages
  logic                                  vr   [0:NS];
  logic [tfun_pkg::LEN2_W-1:0]           len2 [0:NS];
  logic [tfun_pkg::REM_W-1:0]            rem  [0:NS][0:2];
  logic [tfun_pkg::P_W-1:0]              pacc [0:NS][0:2];
  logic [tfun_pkg::Q_W-1:0]              quo  [0:NS][0:2];
  logic [2:0]                            negr [0:NS];
  logic                                  dgr  [0:NS];

  logic signed [tfun_pkg::CROSS_W-1:0]   crs [0:2];
  always_comb begin
    crs[0] = tfun_pkg::CROSS_W'(prd[0]) - tfun_pkg::CROSS_W'(prd[1]);
    crs[1] = tfun_pkg::CROSS_W'(prd[2]) - tfun_pkg::CROSS_W'(prd[3]);
    crs[2] = tfun_pkg::CROSS_W'(prd[4]) - tfun_pkg::CROSS_W'(prd[5]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      vr[0] <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      vr[0] <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dif[i]   <= tfun_pkg::DIFF_W'(vin[i]) - tfun_pkg::DIFF_W'(vin[i+3]);
        dif[i+3] <= tfun_pkg::DIFF_W'(vin[i+3]) - tfun_pkg::DIFF_W'(vin[i+6]);
      end
      // cx = ay*bz - az*by, cy = az*bx - ax*bz, cz = ax*by - ay*bx
      prd[0] <= dif[1] * dif[5];
      prd[1] <= dif[2] * dif[4];
      prd[2] <= dif[2] * dif[3];
      prd[3] <= dif[0] * dif[5];
      prd[4] <= dif[0] * dif[4];
      prd[5] <= dif[1] * dif[3];
      for (int i = 0; i < 3; i++) begin
        mag[i]  <= crs[i][tfun_pkg::CROSS_W-1] ?
                   tfun_pkg::MAG_W'(-crs[i]) : tfun_pkg::MAG_W'(crs[i]);
        neg3[i] <= crs[i][tfun_pkg::CROSS_W-1];
      end
      dg3 <= (crs[0] == '0) && (crs[1] == '0) && (crs[2] == '0);
      for (int i = 0; i < 3; i++) begin
        pp_hh[i] <= mag[i][tfun_pkg::MAG_W-1:tfun_pkg::LO_W] *
                    mag[i][tfun_pkg::MAG_W-1:tfun_pkg::LO_W];
        pp_hl[i] <= mag[i][tfun_pkg::MAG_W-1:tfun_pkg::LO_W] *
                    mag[i][tfun_pkg::LO_W-1:0];
        pp_ll[i] <= mag[i][tfun_pkg::LO_W-1:0] * mag[i][tfun_pkg::LO_W-1:0];
      end
      neg4 <= neg3;
      dg4  <= dg3;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= (tfun_pkg::SQ_W'(pp_hh[i]) << (2 * tfun_pkg::LO_W)) +
                 (tfun_pkg::SQ_W'(pp_hl[i]) << (tfun_pkg::LO_W + 1)) +
                 tfun_pkg::SQ_W'(pp_ll[i]);
      end
      neg5 <= neg4;
      dg5  <= dg4;
      len2[0] <= tfun_pkg::LEN2_W'(sq[0]) + tfun_pkg::LEN2_W'(sq[1]) +
                 tfun_pkg::LEN2_W'(sq[2]);
      for (int i = 0; i < 3; i++) begin
        rem[0][i]  <= tfun_pkg::REM_W'(sq[i]) << (2 * tfun_pkg::FRAC_BITS);
        pacc[0][i] <= '0;
        quo[0][i]  <= '0;
      end
      negr[0] <= neg5;
      dgr[0]  <= dg5;
    end
  end

  // one quotient bit per stage: keep rem = c^2*2^(2F) - q^2*len2, pacc = q*len2
  for (genvar k = 0; k < NS; k++) begin : g_root
    localparam int B = NS - 1 - k;
    logic [tfun_pkg::T_W-1:0] trial [0:2];
    logic [tfun_pkg::T_W-1:0] rext  [0:2];
    logic [2:0]               take;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = (tfun_pkg::T_W'(pacc[k][i]) << (B + 1)) +
                   (tfun_pkg::T_W'(len2[k]) << (2 * B));
        rext[i]  = tfun_pkg::T_W'(rem[k][i]);
        take[i]  = rext[i] >= trial[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k+1] <= 1'b0;
      end else if (en) begin
        vr[k+1] <= vr[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len2[k+1] <= len2[k];
        negr[k+1] <= negr[k];
        dgr[k+1]  <= dgr[k];
        for (int i = 0; i < 3; i++) begin
          if (take[i]) begin
            rem[k+1][i]  <= tfun_pkg::REM_W'(rext[i] - trial[i]);
            pacc[k+1][i] <= pacc[k][i] + (tfun_pkg::P_W'(len2[k]) << B);
            quo[k+1][i]  <= quo[k][i] | (tfun_pkg::Q_W'(1) << B);
          end else begin
            rem[k+1][i]  <= rem[k][i];
            pacc[k+1][i] <= pacc[k][i];
            quo[k+1][i]  <= quo[k][i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vr[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dgr[NS]) begin
          m_axis_tdata[i*NW +: NW] <= '0;
        end else if (negr[NS][i]) begin
          m_axis_tdata[i*NW +: NW] <= NW'(0) - NW'(quo[NS][i]);
        end else begin
          m_axis_tdata[i*NW +: NW] <= NW'(quo[NS][i]);
        end
      end
      m_axis_tuser <= dgr[NS];
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate result carries a nonzero normal");

  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    vr[NS] && !dgr[NS] |->
      quo[NS][0] <= (tfun_pkg::Q_W'(1) << tfun_pkg::FRAC_BITS) &&
      quo[NS][1] <= (tfun_pkg::Q_W'(1) << tfun_pkg::FRAC_BITS) &&
      quo[NS][2] <= (tfun_pkg::Q_W'(1) << tfun_pkg::FRAC_BITS))
    else $error("normal component above one");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams random and corner-case triangles into the unit normal pipeline and
// compares every normal and degenerate flag against an exact integer model.
// ----------------------------------------------------------------------------

class normal_scoreboard;
  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic               degen;
  } normal_t;

  normal_t expected_q[$];
  int      mismatches;

  // floor(sqrt(num/den)) on 15 bits, the true value lies in 0 .. 16384
  static function automatic logic [15:0] unit_mag(logic [255:0] num, logic [255:0] den);
    logic [15:0]  q;
    logic [15:0]  cand;
    logic [255:0] lhs;
    q = 0;
    for (int b = 14; b >= 0; b--) begin
      cand = q | (16'd1 << b);
      lhs  = 256'(cand) * 256'(cand) * den;
      if (lhs <= num) q = cand;
    end
    return q;
  endfunction

  function void note_request(logic [215:0] d);
    logic signed [63:0]  v[9];
    logic signed [63:0]  ax, ay, az, bx, by, bz;
    logic signed [127:0] c[3];
    logic [255:0]        sq[3];
    logic [255:0]        len2;
    logic [15:0]         m;
    logic signed [15:0]  n[3];
    normal_t             e;
    for (int i = 0; i < 9; i++) v[i] = 64'(signed'(d[i*24 +: 24]));
    ax = v[0] - v[3]; ay = v[1] - v[4]; az = v[2] - v[5];
    bx = v[3] - v[6]; by = v[4] - v[7]; bz = v[5] - v[8];
    c[0] = 128'(ay) * 128'(bz) - 128'(az) * 128'(by);
    c[1] = 128'(az) * 128'(bx) - 128'(ax) * 128'(bz);
    c[2] = 128'(ax) * 128'(by) - 128'(ay) * 128'(bx);
    len2 = 0;
    for (int k = 0; k < 3; k++) begin
      sq[k] = 256'(c[k] < 0 ? -c[k] : c[k]);
      sq[k] = sq[k] * sq[k];
      len2  = len2 + sq[k];
    end
    for (int k = 0; k < 3; k++) begin
      n[k] = 0;
      if (len2 != 0) begin
        m    = unit_mag(sq[k] << 28, len2);
        n[k] = c[k] < 0 ? -signed'(m) : signed'(m);
      end
    end
    e.nx = n[0]; e.ny = n[1]; e.nz = n[2];
    e.degen = (len2 == 0);
    expected_q.insert(expected_q.size(), e);
  endfunction

  function void check_result(logic [47:0] d, logic degen);
    normal_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h deg %b", d, degen);
      return;
    end
    e = expected_q.pop_front();
    if (d[15:0] !== e.nx || d[31:16] !== e.ny || d[47:32] !== e.nz || degen !== e.degen) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch exp %0d %0d %0d deg %b got %0d %0d %0d deg %b",
                 e.nx, e.ny, e.nz, e.degen, signed'(d[15:0]), signed'(d[31:16]),
                 signed'(d[47:32]), degen);
    end
  endfunction
endclass

module tb;

  localparam int LIMIT = 20000;
  localparam int N_RANDOM = 450;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [tfun_pkg::IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [tfun_pkg::OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  normal_scoreboard sb = new();
  bit  calm = 0;
  bit  hold_off = 0;
  bit  pressure_start = 0;
  int  idle_cycles = 0;

  triangle_facet_unit_normal_top DUT (.*);

  always #2 clk = ~clk;

  function automatic logic [23:0] rand_coord(int kind);
    case (kind)
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'($urandom_range(0, 15)) - 24'd8;
      default: return 24'($urandom);
    endcase
  endfunction

  // pick with random size class; small coords exercise near-degenerate cases
  function automatic logic [tfun_pkg::IN_W-1:0] rand_triangle();
    logic [tfun_pkg::IN_W-1:0] t;
    int k;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++)
      t[i*24 +: 24] = rand_coord(k < 2 ? $urandom_range(0, 3) : (k < 4 ? 2 : 3));
    if ($urandom_range(0, 15) == 0) t[48 +: 24] = t[0 +: 24];
    if ($urandom_range(0, 15) == 0) t[120 +: 72] = t[48 +: 72];
    return t;
  endfunction

  task automatic send(logic [tfun_pkg::IN_W-1:0] t);
    while (!calm && $urandom_range(0, 99) < 27) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= t;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  function automatic logic [tfun_pkg::IN_W-1:0] pack(logic [23:0] a, b, c, d, e, f, g, h,
                                                      i);
    return {i, h, g, f, e, d, c, b, a};
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (hold_off) m_axis_tready <= 0;
    else m_axis_tready <= calm || ($urandom_range(0, 99) >= 27);
  end

  // hold off the receiver for a long stretch so the pipeline fills
  initial begin
    wait (pressure_start);
    @(posedge clk);
    hold_off <= 1;
    repeat (120) @(posedge clk);
    hold_off <= 0;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    calm = 1;
    send(pack(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(pack(24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff,
              24'h800000, 24'h800000, 24'h800000));
    send(pack(24'h800000, 0, 0, 24'h7fffff, 0, 0, 24'h7fffff, 24'h7fffff, 0));
    send(pack(24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000,
              24'h7fffff, 24'h7fffff, 24'h800000));
    send(pack(4096, 0, 0, 0, 0, 0, 0, 4096, 0));
    send(pack(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    send(pack(0, 0, 4096, 0, 0, 0, 4096, 0, 0));
    send(pack(1, 1, 1, 2, 2, 2, 3, 3, 3));
    send(pack(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send(pack(24'hffffff, 0, 0, 0, 24'hffffff, 0, 0, 0, 24'hffffff));
    send(pack(24'h7fffff, 0, 0, 24'h800000, 0, 0, 24'h7fffff, 1, 0));
    send(pack(24'h123456, 24'h654321, 24'habcdef, 24'h123456, 24'h654321, 24'habcdef,
              24'h0f0f0f, 24'hf0f0f0, 24'h555555));
    pressure_start = 1;
    for (int i = 0; i < 40; i++) send(rand_triangle());
    s_axis_tvalid <= 0;
    repeat (30) @(posedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 200 && i < 300);
      send(rand_triangle());
    end
    s_axis_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end
endmodule
